// ===== rtl/mws_pkg.sv =====
`timescale 1ns / 1ps

package mws_pkg;

    localparam int TARGET_DEPTH = 16;
    localparam int IDX_W        = $clog2(TARGET_DEPTH);
    localparam int COUNT_W      = IDX_W + 1;

    localparam int ANGLE_W = 20;
    localparam int VEL_W   = 23;
    localparam int CUR_W   = 16;
    localparam int TEMP_W  = 8;
    localparam int CODE_W  = 8;
    localparam int CNT16_W = 16;
    localparam int MOVE_W  = 15;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic signed [TEMP_W-1:0] MAX_TEMPERATURE = 8'sd80;

    localparam logic [2:0] REG_MIN_ANGLE = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE = 3'd1;
    localparam logic [2:0] REG_REACH_CNT = 3'd2;
    localparam logic [2:0] REG_MOVE_SPD  = 3'd3;
    localparam logic [2:0] REG_MOVE_ACC  = 3'd4;
    localparam logic [2:0] REG_POS_TOL   = 3'd5;
    localparam logic [2:0] REG_VEL_TOL   = 3'd6;
    localparam logic [2:0] REG_CUR_LIM   = 3'd7;

    localparam logic signed [ANGLE_W-1:0] RST_MIN_ANGLE = 20'sd0;
    localparam logic signed [ANGLE_W-1:0] RST_MAX_ANGLE = 20'sd9000;
    localparam logic [CNT16_W-1:0]        RST_REACH_CNT = 16'd100;
    localparam logic [MOVE_W-1:0]         RST_MOVE_SPD  = 15'd10000;
    localparam logic [MOVE_W-1:0]         RST_MOVE_ACC  = 15'd1000;
    localparam logic [CNT16_W-1:0]        RST_POS_TOL   = 16'd50;
    localparam logic [CNT16_W-1:0]        RST_VEL_TOL   = 16'd20;
    localparam logic [CNT16_W-1:0]        RST_CUR_LIM   = 16'd1600;

    localparam logic OP_FEEDBACK = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_FAULT       = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE       = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERCURRENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_ORIGIN      = 3'd4;
    localparam logic [STAT_W-1:0] ST_HOMING      = 3'd5;
    localparam logic [STAT_W-1:0] ST_LOAD_REJECT = 3'd6;
    localparam logic [STAT_W-1:0] ST_BAD_TARGET  = 3'd7;

    typedef logic signed [ANGLE_W-1:0] angle_t;

endpackage

// ===== rtl/motor_waypoint_sequencer.sv =====
`timescale 1ns / 1ps

// channel   direction  transaction            handshake
// s_*       in         feedback sample/load   s_valid / s_ready
// m_*       out        command + status       m_valid / m_ready
// apb       in         config register r/w    psel / penable / pready
//
// One transaction per cycle sustained while m_ready is high; data passes an
// input register, then a result register. All checks, the phase sequencer
// and the target table update sit between those two registers. Reset is
// synchronous and clears config to defaults, phase state and the target
// table. A stall on m_ready holds the result register; s_ready drops once
// the input register is also full.

module motor_waypoint_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic signed [mws_pkg::ANGLE_W-1:0]  s_position,
    input  logic signed [mws_pkg::VEL_W-1:0]    s_velocity,
    input  logic signed [mws_pkg::CUR_W-1:0]    s_current,
    input  logic signed [mws_pkg::TEMP_W-1:0]   s_temperature,
    input  logic [mws_pkg::CODE_W-1:0]          s_fault_code,
    input  logic [3:0]                          s_entry_index,
    input  logic signed [mws_pkg::ANGLE_W-1:0]  s_target_value,
    input  logic                                s_entry_last,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mws_pkg::KIND_W-1:0]          m_command_kind,
    output logic signed [mws_pkg::ANGLE_W-1:0]  m_command_position,
    output logic [mws_pkg::MOVE_W-1:0]          m_command_speed,
    output logic [mws_pkg::MOVE_W-1:0]          m_command_accel,
    output logic                                m_reached_flag,
    output logic [mws_pkg::STAT_W-1:0]          m_status,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mws_pkg::APB_AW-1:0]          paddr,
    input  logic [mws_pkg::APB_DW-1:0]          pwdata,
    output logic [mws_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    import mws_pkg::*;

    // config registers
    angle_t               min_angle_reg;
    angle_t               max_angle_reg;
    logic [CNT16_W-1:0]   reach_count_reg;
    logic [MOVE_W-1:0]    move_speed_reg;
    logic [MOVE_W-1:0]    move_accel_reg;
    logic [CNT16_W-1:0]   pos_tol_reg;
    logic [CNT16_W-1:0]   vel_tol_reg;
    logic [CNT16_W-1:0]   cur_lim_reg;

    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    // input register
    logic                 in_valid_reg;
    logic                 opcode_reg;
    angle_t               position_reg;
    logic signed [VEL_W-1:0]  velocity_reg;
    logic signed [CUR_W-1:0]  current_reg;
    logic signed [TEMP_W-1:0] temperature_reg;
    logic [CODE_W-1:0]    fault_code_reg;
    logic [3:0]           entry_index_reg;
    angle_t               target_value_reg;
    logic                 entry_last_reg;

    // sequencer state
    logic                 origin_reg, origin_next;
    logic                 homed_reg, homed_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [CNT16_W-1:0]   settle_reg, settle_next;
    logic                 reached_reg, reached_next;
    logic                 loading_reg, loading_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    angle_t               table_reg [TARGET_DEPTH];
    logic                 tbl_we;

    // result register
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    angle_t               cmd_pos_reg, cmd_pos_next;
    logic [MOVE_W-1:0]    cmd_spd_reg, cmd_spd_next;
    logic [MOVE_W-1:0]    cmd_acc_reg, cmd_acc_next;
    logic                 rflag_reg;
    logic [STAT_W-1:0]    status_reg, status_next;

    logic                 in_load;
    logic                 out_load;

    // datapath
    logic [IDX_W-1:0]     wr_idx;
    logic signed [CUR_W:0]     cur_ext;
    logic [CUR_W:0]            cur_mag;
    logic signed [ANGLE_W:0]   pos_ext;
    logic [ANGLE_W:0]          pos_mag;
    logic signed [VEL_W:0]     vel_ext;
    logic [VEL_W:0]            vel_mag;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          diff_mag;
    angle_t               target;
    logic                 near_zero;
    logic                 in_tol;
    logic                 val_bad;
    logic [CNT16_W-1:0]   settle_inc;
    logic [IDX_W-1:0]     ptr_inc;
    logic [COUNT_W-1:0]   count_dec;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_MIN_ANGLE: prdata = APB_DW'(min_angle_reg);
            REG_MAX_ANGLE: prdata = APB_DW'(max_angle_reg);
            REG_REACH_CNT: prdata = APB_DW'(reach_count_reg);
            REG_MOVE_SPD:  prdata = APB_DW'(move_speed_reg);
            REG_MOVE_ACC:  prdata = APB_DW'(move_accel_reg);
            REG_POS_TOL:   prdata = APB_DW'(pos_tol_reg);
            REG_VEL_TOL:   prdata = APB_DW'(vel_tol_reg);
            REG_CUR_LIM:   prdata = APB_DW'(cur_lim_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg   <= RST_MIN_ANGLE;
            max_angle_reg   <= RST_MAX_ANGLE;
            reach_count_reg <= RST_REACH_CNT;
            move_speed_reg  <= RST_MOVE_SPD;
            move_accel_reg  <= RST_MOVE_ACC;
            pos_tol_reg     <= RST_POS_TOL;
            vel_tol_reg     <= RST_VEL_TOL;
            cur_lim_reg     <= RST_CUR_LIM;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MIN_ANGLE: min_angle_reg   <= pwdata[ANGLE_W-1:0];
                REG_MAX_ANGLE: max_angle_reg   <= pwdata[ANGLE_W-1:0];
                REG_REACH_CNT: reach_count_reg <= pwdata[CNT16_W-1:0];
                REG_MOVE_SPD:  move_speed_reg  <= pwdata[MOVE_W-1:0];
                REG_MOVE_ACC:  move_accel_reg  <= pwdata[MOVE_W-1:0];
                REG_POS_TOL:   pos_tol_reg     <= pwdata[CNT16_W-1:0];
                REG_VEL_TOL:   vel_tol_reg     <= pwdata[CNT16_W-1:0];
                REG_CUR_LIM:   cur_lim_reg     <= pwdata[CNT16_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            opcode_reg       <= s_opcode;
            position_reg     <= s_position;
            velocity_reg     <= s_velocity;
            current_reg      <= s_current;
            temperature_reg  <= s_temperature;
            fault_code_reg   <= s_fault_code;
            entry_index_reg  <= s_entry_index;
            target_value_reg <= s_target_value;
            entry_last_reg   <= s_entry_last;
        end
    end

    // ---------------- checks ----------------
    assign wr_idx   = entry_index_reg[IDX_W-1:0];
    assign target   = table_reg[ptr_reg];

    assign cur_ext  = {current_reg[CUR_W-1], current_reg};
    assign cur_mag  = cur_ext[CUR_W] ? (CUR_W+1)'(-cur_ext) : (CUR_W+1)'(cur_ext);
    assign pos_ext  = {position_reg[ANGLE_W-1], position_reg};
    assign pos_mag  = pos_ext[ANGLE_W] ? (ANGLE_W+1)'(-pos_ext) : (ANGLE_W+1)'(pos_ext);
    assign vel_ext  = {velocity_reg[VEL_W-1], velocity_reg};
    assign vel_mag  = vel_ext[VEL_W] ? (VEL_W+1)'(-vel_ext) : (VEL_W+1)'(vel_ext);
    assign diff     = pos_ext - {target[ANGLE_W-1], target};
    assign diff_mag = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : (ANGLE_W+1)'(diff);

    assign near_zero = (pos_mag < (ANGLE_W+1)'(pos_tol_reg)) &&
                       (vel_mag < (VEL_W+1)'(vel_tol_reg));
    assign in_tol    = diff_mag < (ANGLE_W+1)'(pos_tol_reg);
    assign val_bad   = (target_value_reg < min_angle_reg) ||
                       (target_value_reg > max_angle_reg) ||
                       ({1'b0, entry_index_reg} >= 5'(TARGET_DEPTH));

    assign settle_inc = (settle_reg != {CNT16_W{1'b1}}) ? settle_reg + 1'b1 : settle_reg;
    assign ptr_inc    = ptr_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;

    // ---------------- sequencer ----------------
    always_comb begin
        origin_next  = origin_reg;
        homed_next   = homed_reg;
        ptr_next     = ptr_reg;
        settle_next  = settle_reg;
        reached_next = reached_reg;
        loading_next = loading_reg;
        count_next   = count_reg;
        tbl_we       = 1'b0;
        kind_next    = KIND_NONE;
        cmd_pos_next = '0;
        cmd_spd_next = '0;
        cmd_acc_next = '0;
        status_next  = ST_OK;

        if (opcode_reg == OP_LOAD) begin
            priority if (!loading_reg && !(origin_reg && reached_reg)) begin
                status_next = ST_LOAD_REJECT;
            end else if (val_bad) begin
                loading_next = 1'b0;
                status_next  = ST_BAD_TARGET;
            end else begin
                tbl_we       = 1'b1;
                loading_next = 1'b1;
                if (entry_last_reg) begin
                    count_next   = COUNT_W'(entry_index_reg) + 1'b1;
                    ptr_next     = '0;
                    reached_next = 1'b0;
                    loading_next = 1'b0;
                end
            end
        end else begin
            priority if (temperature_reg > MAX_TEMPERATURE || fault_code_reg != '0) begin
                kind_next   = KIND_STOP;
                status_next = ST_FAULT;
            end else if (position_reg < min_angle_reg || position_reg > max_angle_reg) begin
                kind_next   = KIND_STOP;
                status_next = ST_RANGE;
            end else if (cur_mag > (CUR_W+1)'(cur_lim_reg)) begin
                kind_next   = KIND_STOP;
                status_next = ST_OVERCURRENT;
            end else if (!origin_reg) begin
                status_next = ST_ORIGIN;
                if (near_zero) begin
                    origin_next = 1'b1;
                end
            end else if (!homed_reg) begin
                kind_next    = KIND_MOVE;
                cmd_spd_next = move_speed_reg;
                cmd_acc_next = move_accel_reg;
                status_next  = ST_HOMING;
                if (near_zero) begin
                    homed_next   = 1'b1;
                    reached_next = 1'b1;
                end
            end else begin
                kind_next    = KIND_MOVE;
                cmd_pos_next = target;
                cmd_spd_next = move_speed_reg;
                cmd_acc_next = move_accel_reg;
                if (in_tol) begin
                    if (settle_inc >= reach_count_reg) begin
                        settle_next  = '0;
                        reached_next = 1'b1;
                        if (ptr_inc == '0 || COUNT_W'(ptr_inc) >= count_reg) begin
                            ptr_next = (count_reg != '0) ? count_dec[IDX_W-1:0] : '0;
                        end else begin
                            ptr_next = ptr_inc;
                        end
                    end else begin
                        settle_next = settle_inc;
                    end
                end else begin
                    settle_next  = '0;
                    reached_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg  <= 1'b0;
            homed_reg   <= 1'b0;
            ptr_reg     <= '0;
            settle_reg  <= '0;
            reached_reg <= 1'b1;
            loading_reg <= 1'b0;
            count_reg   <= COUNT_W'(1);
            for (int i = 0; i < TARGET_DEPTH; i++) begin
                table_reg[i] <= '0;
            end
        end else if (out_load) begin
            origin_reg  <= origin_next;
            homed_reg   <= homed_next;
            ptr_reg     <= ptr_next;
            settle_reg  <= settle_next;
            reached_reg <= reached_next;
            loading_reg <= loading_next;
            count_reg   <= count_next;
            if (tbl_we) begin
                table_reg[wr_idx] <= target_value_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg    <= kind_next;
            cmd_pos_reg <= cmd_pos_next;
            cmd_spd_reg <= cmd_spd_next;
            cmd_acc_reg <= cmd_acc_next;
            rflag_reg   <= reached_next;
            status_reg  <= status_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_command_kind     = kind_reg;
    assign m_command_position = cmd_pos_reg;
    assign m_command_speed    = cmd_spd_reg;
    assign m_command_accel    = cmd_acc_reg;
    assign m_reached_flag     = rflag_reg;
    assign m_status           = status_reg;

    // ---------------- assertions ----------------
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= COUNT_W'(TARGET_DEPTH))
        else $error("target count out of range");

    a_ptr_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        COUNT_W'(ptr_reg) < count_reg)
        else $error("target pointer beyond loaded table");

    a_homed_after_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        homed_reg |-> origin_reg)
        else $error("homed without origin confirmation");

    a_stop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg == KIND_STOP) |->
        ((status_reg == ST_FAULT || status_reg == ST_RANGE ||
          status_reg == ST_OVERCURRENT) && cmd_spd_reg == '0 && cmd_pos_reg == '0))
        else $error("stop command with wrong status or payload");

endmodule

// ===== sim/motor_waypoint_sequencer_tb.sv =====
`timescale 1ns / 1ps

module motor_waypoint_sequencer_tb;
    import mws_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic                opcode;
        angle_t              position;
        logic signed [VEL_W-1:0]  velocity;
        logic signed [CUR_W-1:0]  current;
        logic signed [TEMP_W-1:0] temperature;
        logic [CODE_W-1:0]   fault_code;
        logic [3:0]          entry_index;
        angle_t              target_value;
        logic                entry_last;
    } feed_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        angle_t            position;
        logic [MOVE_W-1:0] speed;
        logic [MOVE_W-1:0] accel;
        logic              reached;
        logic [STAT_W-1:0] status;
    } cmd_t;

    typedef enum {RDY_FULL, RDY_MOSTLY, RDY_PERIODIC, RDY_SPARSE} rdy_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic                      s_opcode       = OP_FEEDBACK;
    logic signed [ANGLE_W-1:0] s_position     = '0;
    logic signed [VEL_W-1:0]   s_velocity     = '0;
    logic signed [CUR_W-1:0]   s_current      = '0;
    logic signed [TEMP_W-1:0]  s_temperature  = '0;
    logic [CODE_W-1:0]         s_fault_code   = '0;
    logic [3:0]                s_entry_index  = '0;
    logic signed [ANGLE_W-1:0] s_target_value = '0;
    logic                      s_entry_last   = 1'b0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [KIND_W-1:0]         m_command_kind;
    logic signed [ANGLE_W-1:0] m_command_position;
    logic [MOVE_W-1:0]         m_command_speed;
    logic [MOVE_W-1:0]         m_command_accel;
    logic                      m_reached_flag;
    logic [STAT_W-1:0]         m_status;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    motor_waypoint_sequencer u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_position         (s_position),
        .s_velocity         (s_velocity),
        .s_current          (s_current),
        .s_temperature      (s_temperature),
        .s_fault_code       (s_fault_code),
        .s_entry_index      (s_entry_index),
        .s_target_value     (s_target_value),
        .s_entry_last       (s_entry_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_command_kind     (m_command_kind),
        .m_command_position (m_command_position),
        .m_command_speed    (m_command_speed),
        .m_command_accel    (m_command_accel),
        .m_reached_flag     (m_reached_flag),
        .m_status           (m_status),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // shadow configuration
    angle_t              cfg_min, cfg_max;
    logic [CNT16_W-1:0]  cfg_reach, cfg_ptol, cfg_vtol, cfg_ilim;
    logic [MOVE_W-1:0]   cfg_speed, cfg_accel;

    // shadow sequencer state
    logic                origin_ok, homed_q, reached_q, loading_q;
    logic [3:0]          tgt_ptr;
    logic [15:0]         settle_cnt;
    logic [COUNT_W-1:0]  tgt_cnt;
    angle_t              tgt_tab [TARGET_DEPTH];

    feed_t item_q[$];
    cmd_t  cmd_exp_q[$];
    feed_t drv_item;

    // stimulus-side guess of the loaded table
    angle_t plan_tab [TARGET_DEPTH];
    int     plan_cnt;
    int     plan_ptr;

    int burst_left = 0;
    int gap_left   = 0;
    int cycle_cnt  = 0;
    int mismatch_cnt = 0;
    int stall_left = 0;
    int stall_phase = 0;
    rdy_mode_t stall_mode = RDY_FULL;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void reset_model();
        cfg_min    = RST_MIN_ANGLE;
        cfg_max    = RST_MAX_ANGLE;
        cfg_reach  = RST_REACH_CNT;
        cfg_speed  = RST_MOVE_SPD;
        cfg_accel  = RST_MOVE_ACC;
        cfg_ptol   = RST_POS_TOL;
        cfg_vtol   = RST_VEL_TOL;
        cfg_ilim   = RST_CUR_LIM;
        origin_ok  = 1'b0;
        homed_q    = 1'b0;
        reached_q  = 1'b1;
        loading_q  = 1'b0;
        tgt_ptr    = '0;
        settle_cnt = '0;
        tgt_cnt    = COUNT_W'(1);
        for (int i = 0; i < TARGET_DEPTH; i++) begin
            tgt_tab[i]  = '0;
            plan_tab[i] = '0;
        end
        plan_cnt = 1;
        plan_ptr = 0;
    endfunction

    function automatic cmd_t predict_command(input feed_t it);
        cmd_t   r;
        longint pos, vel, tgt;
        logic   near_zero;
        r = '0;
        pos = it.position;
        vel = it.velocity;
        if (it.opcode == OP_LOAD) begin
            r.kind = KIND_NONE;
            if (!loading_q && !(origin_ok && reached_q)) begin
                r.status = ST_LOAD_REJECT;
            end else if (it.target_value < cfg_min || it.target_value > cfg_max) begin
                loading_q = 1'b0;
                r.status  = ST_BAD_TARGET;
            end else begin
                tgt_tab[it.entry_index] = it.target_value;
                loading_q = 1'b1;
                if (it.entry_last) begin
                    tgt_cnt   = COUNT_W'(it.entry_index) + COUNT_W'(1);
                    tgt_ptr   = '0;
                    reached_q = 1'b0;
                    loading_q = 1'b0;
                end
                r.status = ST_OK;
            end
        end else if (it.temperature > MAX_TEMPERATURE || it.fault_code != '0) begin
            r.kind   = KIND_STOP;
            r.status = ST_FAULT;
        end else if (it.position < cfg_min || it.position > cfg_max) begin
            r.kind   = KIND_STOP;
            r.status = ST_RANGE;
        end else if (abs_l(longint'(it.current)) > longint'(cfg_ilim)) begin
            r.kind   = KIND_STOP;
            r.status = ST_OVERCURRENT;
        end else begin
            near_zero = (abs_l(pos) < longint'(cfg_ptol)) &&
                        (abs_l(vel) < longint'(cfg_vtol));
            if (!origin_ok) begin
                if (near_zero)
                    origin_ok = 1'b1;
                r.kind   = KIND_NONE;
                r.status = ST_ORIGIN;
            end else if (!homed_q) begin
                if (near_zero) begin
                    homed_q   = 1'b1;
                    reached_q = 1'b1;
                end
                r.kind   = KIND_MOVE;
                r.speed  = cfg_speed;
                r.accel  = cfg_accel;
                r.status = ST_HOMING;
            end else begin
                r.position = tgt_tab[tgt_ptr];
                tgt = tgt_tab[tgt_ptr];
                if (abs_l(pos - tgt) < longint'(cfg_ptol)) begin
                    if (settle_cnt != 16'hFFFF)
                        settle_cnt = settle_cnt + 16'd1;
                    if (settle_cnt >= cfg_reach) begin
                        settle_cnt = '0;
                        reached_q  = 1'b1;
                        tgt_ptr    = tgt_ptr + 4'd1;
                        if (tgt_ptr == '0 || COUNT_W'(tgt_ptr) >= tgt_cnt)
                            tgt_ptr = 4'(tgt_cnt - COUNT_W'(1));
                    end
                end else begin
                    settle_cnt = '0;
                    reached_q  = 1'b0;
                end
                r.kind   = KIND_MOVE;
                r.speed  = cfg_speed;
                r.accel  = cfg_accel;
                r.status = ST_OK;
            end
        end
        r.reached = reached_q;
        return r;
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                cmd_exp_q = {cmd_exp_q, predict_command(drv_item)};
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    drv_item = item_q.pop_front();
                    s_opcode       <= drv_item.opcode;
                    s_position     <= drv_item.position;
                    s_velocity     <= drv_item.velocity;
                    s_current      <= drv_item.current;
                    s_temperature  <= drv_item.temperature;
                    s_fault_code   <= drv_item.fault_code;
                    s_entry_index  <= drv_item.entry_index;
                    s_target_value <= drv_item.target_value;
                    s_entry_last   <= drv_item.entry_last;
                    s_valid        <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction, stalls on its own pattern
    always @(posedge aclk) begin
        cmd_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.kind     = m_command_kind;
                got.position = m_command_position;
                got.speed    = m_command_speed;
                got.accel    = m_command_accel;
                got.reached  = m_reached_flag;
                got.status   = m_status;
                if (cmd_exp_q.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10)
                        $display({"unexpected result: ",
                                  "kind=%0d pos=%0d spd=%0d acc=%0d rch=%0d st=%0d"},
                                 got.kind, got.position, got.speed, got.accel,
                                 got.reached, got.status);
                end else begin
                    want = cmd_exp_q.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.speed !== want.speed || got.accel !== want.accel ||
                        got.reached !== want.reached || got.status !== want.status) begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: exp kind=%0d pos=%0d spd=%0d acc=%0d ",
                                      "rch=%0d st=%0d | got kind=%0d pos=%0d spd=%0d ",
                                      "acc=%0d rch=%0d st=%0d"},
                                     want.kind, want.position, want.speed, want.accel,
                                     want.reached, want.status, got.kind, got.position,
                                     got.speed, got.accel, got.reached, got.status);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = rdy_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(40, 300);
            end else begin
                stall_left = stall_left - 1;
            end
            stall_phase = (stall_phase + 1) % 7;
            case (stall_mode)
                RDY_FULL:     m_ready <= 1'b1;
                RDY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                RDY_PERIODIC: m_ready <= (stall_phase < 4);
                default:      m_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic longint rand_span(input longint lo, input longint hi);
        if (hi <= lo)
            return lo;
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic longint tol_offset(input longint tol);
        if (tol <= 0)
            return 0;
        return rand_span(-(tol - 1), tol - 1);
    endfunction

    function automatic angle_t clip_angle(input longint v);
        longint lo, hi;
        lo = cfg_min;
        hi = cfg_max;
        if (lo > hi) begin
            lo = -360000;
            hi = 360000;
        end
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return angle_t'(v);
    endfunction

    function automatic feed_t base_item(input logic op);
        feed_t it;
        it.opcode       = op;
        it.position     = angle_t'(rand_span(-360000, 360000));
        it.velocity     = VEL_W'(rand_span(-3276800, 3276799));
        it.current      = CUR_W'($urandom);
        it.temperature  = TEMP_W'($urandom);
        it.fault_code   = CODE_W'($urandom);
        it.entry_index  = 4'($urandom);
        it.target_value = angle_t'(rand_span(-360000, 360000));
        it.entry_last   = 1'($urandom);
        return it;
    endfunction

    // sample that passes every safety check under the current settings
    function automatic feed_t safe_sample(input longint pos, input longint vel);
        feed_t  it;
        longint lim;
        it = base_item(OP_FEEDBACK);
        lim = (cfg_ilim > 16'd32767) ? 32767 : longint'(cfg_ilim);
        it.position    = clip_angle(pos);
        it.velocity    = VEL_W'(vel);
        it.current     = CUR_W'(rand_span(-lim, lim));
        it.temperature = TEMP_W'(rand_span(-128, MAX_TEMPERATURE));
        it.fault_code  = '0;
        return it;
    endfunction

    function automatic longint rand_vel();
        if ($urandom_range(0, 1) == 0)
            return tol_offset(longint'(cfg_vtol));
        return rand_span(-3276800, 3276799);
    endfunction

    task automatic push_feed(input longint pos, input longint vel, input longint cur,
                             input longint temp, input longint code);
        feed_t it;
        it = base_item(OP_FEEDBACK);
        it.position    = angle_t'(pos);
        it.velocity    = VEL_W'(vel);
        it.current     = CUR_W'(cur);
        it.temperature = TEMP_W'(temp);
        it.fault_code  = CODE_W'(code);
        item_q = {item_q, it};
    endtask

    task automatic push_load(input int idx, input longint val, input logic last);
        feed_t it;
        it = base_item(OP_LOAD);
        it.entry_index  = 4'(idx);
        it.target_value = angle_t'(val);
        it.entry_last   = last;
        item_q = {item_q, it};
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || s_valid || cmd_exp_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_ANGLE: cfg_min   = angle_t'(value);
            REG_MAX_ANGLE: cfg_max   = angle_t'(value);
            REG_REACH_CNT: cfg_reach = CNT16_W'(value);
            REG_MOVE_SPD:  cfg_speed = MOVE_W'(value);
            REG_MOVE_ACC:  cfg_accel = MOVE_W'(value);
            REG_POS_TOL:   cfg_ptol  = CNT16_W'(value);
            REG_VEL_TOL:   cfg_vtol  = CNT16_W'(value);
            default:       cfg_ilim  = CNT16_W'(value);
        endcase
    endtask

    task automatic gen_random(input int n);
        int     made, r, len, k, bad;
        longint lim, v;
        feed_t  it;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // table load sequence, occasionally with one bad entry
                len = ($urandom_range(0, 7) == 0) ? TARGET_DEPTH : $urandom_range(1, 4);
                bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
                for (k = 0; k < len; k++) begin
                    it = base_item(OP_LOAD);
                    it.entry_index = 4'(k);
                    it.entry_last  = (k == len - 1);
                    if (k == bad) begin
                        if (cfg_max < 360000)
                            v = rand_span(longint'(cfg_max) + 1, 360000);
                        else
                            v = rand_span(-360000, longint'(cfg_min) - 1);
                        it.target_value = angle_t'(v);
                    end else begin
                        it.target_value = clip_angle(rand_span(cfg_min, cfg_max));
                        plan_tab[k] = it.target_value;
                    end
                    item_q = {item_q, it};
                end
                if (bad < 0) begin
                    plan_cnt = len;
                    plan_ptr = 0;
                end
                made += len;
            end else if (r < 55) begin
                // settle on the current target, long enough to advance when reach <= 6
                k = (cfg_reach > 16'd6) ? 6 : int'(cfg_reach) + $urandom_range(0, 1);
                repeat (k) begin
                    v = longint'(plan_tab[plan_ptr]) + tol_offset(longint'(cfg_ptol));
                    item_q = {item_q, safe_sample(v, rand_vel())};
                end
                if (plan_ptr + 1 < plan_cnt)
                    plan_ptr = plan_ptr + 1;
                made += k;
            end else if (r < 63) begin
                item_q = {item_q, safe_sample(tol_offset(longint'(cfg_ptol)),
                                              tol_offset(longint'(cfg_vtol)))};
                made++;
            end else if (r < 71) begin
                it = safe_sample(rand_span(cfg_min, cfg_max), rand_vel());
                if ($urandom_range(0, 1) == 0)
                    it.temperature = TEMP_W'(rand_span(81, 127));
                else
                    it.fault_code = CODE_W'(rand_span(1, 255));
                item_q = {item_q, it};
                made++;
            end else if (r < 79) begin
                it = safe_sample(0, rand_vel());
                if (cfg_max < 360000 && $urandom_range(0, 1) == 0)
                    it.position = angle_t'(rand_span(longint'(cfg_max) + 1, 360000));
                else if (cfg_min > -360000)
                    it.position = angle_t'(rand_span(-360000, longint'(cfg_min) - 1));
                else
                    it.position = angle_t'(rand_span(-360000, 360000));
                item_q = {item_q, it};
                made++;
            end else if (r < 87) begin
                it = safe_sample(rand_span(cfg_min, cfg_max), rand_vel());
                lim = cfg_ilim;
                if (lim < 32767) begin
                    if ($urandom_range(0, 1) == 0)
                        it.current = CUR_W'(rand_span(lim + 1, 32767));
                    else
                        it.current = CUR_W'(rand_span(-32768, -(lim + 1)));
                end
                item_q = {item_q, it};
                made++;
            end else begin
                item_q = {item_q, base_item(1'($urandom))};
                made++;
            end
        end
    endtask

    task automatic run_phase(input int minv, input int maxv, input int reach, input int spd,
                             input int acc, input int ptol, input int vtol, input int ilim,
                             input int n);
        wait_idle();
        cfg_write(REG_MIN_ANGLE, minv);
        cfg_write(REG_MAX_ANGLE, maxv);
        cfg_write(REG_REACH_CNT, reach);
        cfg_write(REG_MOVE_SPD, spd);
        cfg_write(REG_MOVE_ACC, acc);
        cfg_write(REG_POS_TOL, ptol);
        cfg_write(REG_VEL_TOL, vtol);
        cfg_write(REG_CUR_LIM, ilim);
        gen_random(n);
    endtask

    initial begin
        reset_model();
        wait (aresetn);
        @(posedge aclk);

        // directed: safety checks, origin, homing, load corner cases
        push_load(0, 100, 1'b1);
        push_feed(0, 0, 0, 127, 0);
        push_feed(0, 0, 0, 81, 0);
        push_feed(0, 0, 0, 0, 255);
        push_feed(-1, 0, 0, 0, 0);
        push_feed(9001, 0, 0, 0, 0);
        push_feed(-360000, 0, 0, 0, 0);
        push_feed(360000, 0, 0, 0, 0);
        push_feed(100, 0, 1601, 0, 0);
        push_feed(100, 0, -32768, -128, 0);
        push_feed(100, 3276799, -1600, 80, 0);
        push_feed(0, -3276800, 0, 0, 0);
        push_feed(49, -19, 1600, 0, 0);
        push_feed(500, 0, 0, 0, 0);
        push_feed(0, 0, 0, 0, 0);
        push_feed(10, 0, 0, 0, 0);
        push_load(0, 9000, 1'b0);
        push_load(1, 9001, 1'b0);
        push_load(15, 0, 1'b1);
        push_load(3, 10, 1'b1);
        push_feed(9000, 0, 0, 0, 0);
        push_feed(8000, 0, 0, 0, 0);
        push_load(0, 0, 1'b0);
        plan_tab[0] = angle_t'(9000);
        plan_cnt = TARGET_DEPTH;

        run_phase(-360000, 360000, 1, 32767, 0, 65535, 65535, 65535, 200);
        run_phase(-20000, 20000, 2, 0, 32767, 100, 50, 3000, 200);
        run_phase(-360000, 360000, 3, 123, 456, 0, 0, 0, 120);
        run_phase(0, 9000, 65535, 10000, 1000, 50, 20, 1600, 40);
        repeat (4) begin
            run_phase(int'(rand_span(-360000, 0)), int'(rand_span(1000, 360000)),
                      $urandom_range(1, 4), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), $urandom_range(1, 2000),
                      $urandom_range(0, 65535), $urandom_range(200, 32767), 200);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
